/* src/rbt_pkg.sv */
// rbt_pkg: shared types, field widths and codes of the resource barrier tracker
// used by rbt_front, rbt_back and resource_barrier_tracker
package rbt_pkg;

   // fixed field widths of the request and response
   localparam int KIND_W = 3;
   localparam int IDX_W  = 8;
   localparam int ACC_W  = 4;
   localparam int STEP_W = 10;

   // default sizes
   localparam int DEF_MAX_RESOURCES = 256;
   localparam int DEF_MAX_STEPS     = 1024;

   // depth of the queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_DECLARE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_USE       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_END_PASS  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FINAL     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEW_FRAME = 3'd4;

   // classified operations handed to the back end
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
   localparam logic [OP_W-1:0] OP_DECLARE = 3'd1;
   localparam logic [OP_W-1:0] OP_USE     = 3'd2;
   localparam logic [OP_W-1:0] OP_STEP    = 3'd3;
   localparam logic [OP_W-1:0] OP_FINAL   = 3'd4;
   localparam logic [OP_W-1:0] OP_FRAME   = 3'd5;

   // access and queue codes with special meaning
   localparam logic [ACC_W-1:0] ACC_NONE         = 4'd0;
   localparam logic [ACC_W-1:0] ACC_SHADER_WRITE = 4'd5;
   localparam logic             QUEUE_GRAPHICS   = 1'b0;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic [ACC_W-1:0] acc;
      logic             pass_q;
   } rbt_item_type;

   typedef struct packed {
      logic              barrier_valid;
      logic [IDX_W-1:0]  barrier_resource;
      logic [ACC_W-1:0]  from_access;
      logic [ACC_W-1:0]  to_access;
      logic              queue_crossing;
      logic              from_queue;
      logic              to_queue;
      logic [STEP_W-1:0] release_step;
      logic [STEP_W-1:0] current_step;
      logic              step_overflow;
   } rbt_result_type;

endpackage

/* src/resource_barrier_tracker.sv */
// resource_barrier_tracker: top level of the render graph barrier tracker
// depends on rbt_pkg, rbt_ram, rbt_front and rbt_back
//
// usage
//   request channel: a transfer happens at a rising edge with start high and
//     busy low; req_kind selects declare, use, end of pass, final or new frame
//   response channel: every request gives exactly one response, shown for one
//     cycle with rsp_strobe high; the receiver has no way to hold it off
//   with the back end idle an accepted request passes through the queue entry,
//     the current item register with the ram read, then the response register
//   the back end takes a new request only once the last one is through: the ram
//     is read on the pop in the idle state, compare and write back in execute
//   a 2-entry queue sits between the intake and the back end; busy is high
//     while that queue is full
//   reset: synchronous, active high; clears the queue, the step counter and
//     the ownership valid bits, then the back end zeroes the table ram, one
//     entry a cycle until all MAX_RESOURCES are zero; requests queue up meanwhile
//   a new frame clears the ownership valid bits at once, keeping access state
module resource_barrier_tracker #(
   parameter int MAX_RESOURCES = rbt_pkg::DEF_MAX_RESOURCES,
   parameter int MAX_STEPS     = rbt_pkg::DEF_MAX_STEPS
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  logic [rbt_pkg::KIND_W-1:0]  req_kind,
   input  logic [rbt_pkg::IDX_W-1:0]   req_resource_index,
   input  logic [rbt_pkg::ACC_W-1:0]   req_access_code,
   input  logic                        req_pass_queue,
   // response channel
   output logic                        rsp_strobe,
   output logic                        rsp_barrier_valid,
   output logic [rbt_pkg::IDX_W-1:0]   rsp_barrier_resource,
   output logic [rbt_pkg::ACC_W-1:0]   rsp_from_access,
   output logic [rbt_pkg::ACC_W-1:0]   rsp_to_access,
   output logic                        rsp_queue_crossing,
   output logic                        rsp_from_queue,
   output logic                        rsp_to_queue,
   output logic [rbt_pkg::STEP_W-1:0]  rsp_release_step,
   output logic [rbt_pkg::STEP_W-1:0]  rsp_current_step,
   output logic                        rsp_step_overflow
);

   import rbt_pkg::*;

   localparam int AW = $clog2(MAX_RESOURCES);
   // entry: access, owner queue, used bit, owner step
   localparam int EW = $clog2(MAX_STEPS) + 6;

   // queue between front and back
   logic           item_valid;
   rbt_item_type   item;
   logic           item_pop;

   // table ram ports
   logic           ram_rd_en;
   logic [AW-1:0]  ram_rd_addr;
   logic [EW-1:0]  ram_rd_data;
   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   logic [EW-1:0]  ram_wr_data;

   rbt_result_type rsp;

   // intake: classify each transfer and queue it
   rbt_front #(
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_resource_index (req_resource_index),
      .req_access_code    (req_access_code),
      .req_pass_queue     (req_pass_queue),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop)
   );

   // per-resource table
   rbt_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_RESOURCES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // execution: table read-modify-write, step counter, response register
   rbt_back #(
      .MAX_RESOURCES (MAX_RESOURCES),
      .MAX_STEPS     (MAX_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp)
   );

   // response fields onto their ports
   assign rsp_barrier_valid    = rsp.barrier_valid;
   assign rsp_barrier_resource = rsp.barrier_resource;
   assign rsp_from_access      = rsp.from_access;
   assign rsp_to_access        = rsp.to_access;
   assign rsp_queue_crossing   = rsp.queue_crossing;
   assign rsp_from_queue       = rsp.from_queue;
   assign rsp_to_queue         = rsp.to_queue;
   assign rsp_release_step     = rsp.release_step;
   assign rsp_current_step     = rsp.current_step;
   assign rsp_step_overflow    = rsp.step_overflow;

endmodule

/* src/rbt_ram.sv */
// rbt_ram: generic single write port, single read port ram with registered read
// no dependencies
module rbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rbt_front.sv */
// rbt_front: request intake, classification and the queue toward the back end
// depends on rbt_pkg
module rbt_front #(
   parameter int MAX_RESOURCES = rbt_pkg::DEF_MAX_RESOURCES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [rbt_pkg::KIND_W-1:0] req_kind,
   input  logic [rbt_pkg::IDX_W-1:0]  req_resource_index,
   input  logic [rbt_pkg::ACC_W-1:0]  req_access_code,
   input  logic                       req_pass_queue,
   output logic                       item_valid,
   output rbt_pkg::rbt_item_type      item,
   input  logic                       item_pop
);

   import rbt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rbt_item_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               idx_ok;
   rbt_item_type       classified;

   // unknown kinds, and declare, use or final out of range, become no-ops
   always_comb begin
      idx_ok              = 32'(req_resource_index) < MAX_RESOURCES;
      classified.idx      = req_resource_index;
      classified.acc      = req_access_code;
      classified.pass_q   = req_pass_queue;
      case (req_kind)
         KIND_DECLARE:   classified.op = idx_ok ? OP_DECLARE : OP_NONE;
         KIND_USE:       classified.op = idx_ok ? OP_USE : OP_NONE;
         KIND_END_PASS:  classified.op = OP_STEP;
         KIND_FINAL:     classified.op = idx_ok ? OP_FINAL : OP_NONE;
         KIND_NEW_FRAME: classified.op = OP_FRAME;
         default:        classified.op = OP_NONE;
      endcase
   end

   assign busy       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* src/rbt_back.sv */
// rbt_back: table read-modify-write, step counter and response register
// depends on rbt_pkg; drives an rbt_ram instance through its ram ports
module rbt_back #(
   parameter int MAX_RESOURCES = rbt_pkg::DEF_MAX_RESOURCES,
   parameter int MAX_STEPS     = rbt_pkg::DEF_MAX_STEPS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  rbt_pkg::rbt_item_type               item,
   output logic                                item_pop,
   output logic                                ram_rd_en,
   output logic [$clog2(MAX_RESOURCES)-1:0]    ram_rd_addr,
   input  logic [$clog2(MAX_STEPS)+5:0]        ram_rd_data,
   output logic                                ram_wr_en,
   output logic [$clog2(MAX_RESOURCES)-1:0]    ram_wr_addr,
   output logic [$clog2(MAX_STEPS)+5:0]        ram_wr_data,
   output logic                                rsp_strobe,
   output rbt_pkg::rbt_result_type             rsp
);

   import rbt_pkg::*;

   localparam int AW = $clog2(MAX_RESOURCES);
   localparam int SW = $clog2(MAX_STEPS);
   // entry layout: access, owner queue, used bit, owner step
   localparam int USED_BIT  = SW;
   localparam int QUEUE_BIT = SW + 1;
   localparam int ACC_LO    = SW + 2;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [AW-1:0]            sweep_ff, sweep_in;
   rbt_item_type             cur_ff, cur_in;
   logic [SW-1:0]            step_ff, step_in;
   logic [MAX_RESOURCES-1:0] own_valid_ff, own_valid_in;
   logic                     strobe_ff, strobe_in;
   rbt_result_type           rsp_ff, rsp_in, rsp_out;

   logic [31:0]      head_idx_wide, cur_idx_wide, owner_step_wide, step_out_wide;
   logic [AW-1:0]    cur_addr;
   logic [ACC_W-1:0] eff_acc;
   logic             eff_queue, eff_used;
   logic [SW-1:0]    eff_step;
   logic             crosses, barrier, saturated;

   assign head_idx_wide = 32'(item.idx);
   assign cur_idx_wide  = 32'(cur_ff.idx);
   assign cur_addr      = cur_idx_wide[AW-1:0];

   assign item_pop    = (state_ff == ST_IDLE) && item_valid;
   assign ram_rd_en   = item_pop;
   assign ram_rd_addr = head_idx_wide[AW-1:0];

   // ownership not written since the frame started reads as zero
   always_comb begin
      eff_acc   = ram_rd_data[ACC_LO +: ACC_W];
      eff_queue = own_valid_ff[cur_addr] ? ram_rd_data[QUEUE_BIT] : QUEUE_GRAPHICS;
      eff_used  = own_valid_ff[cur_addr] ? ram_rd_data[USED_BIT] : 1'b0;
      eff_step  = own_valid_ff[cur_addr] ? ram_rd_data[SW-1:0] : '0;
   end

   assign crosses         = (cur_ff.pass_q != eff_queue) && eff_used;
   // every shader write use gets a barrier even without a state change
   assign barrier         = (eff_acc != cur_ff.acc) || crosses
                            || (cur_ff.acc == ACC_SHADER_WRITE);
   assign saturated       = 32'(step_ff) >= MAX_STEPS - 1;
   assign owner_step_wide = 32'(eff_step);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      own_valid_in = own_valid_ff;
      strobe_in    = 1'b0;
      rsp_in       = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_addr;
      ram_wr_data  = {eff_acc, eff_queue, eff_used, eff_step};

      case (state_ff)
         ST_CLEAR: begin
            // zero one table entry per cycle after reset
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == AW'(MAX_RESOURCES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               cur_in   = item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            case (cur_ff.op)
               OP_DECLARE: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {cur_ff.acc, QUEUE_GRAPHICS, 1'b0, {SW{1'b0}}};
               end
               OP_USE: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {cur_ff.acc, cur_ff.pass_q, 1'b1, step_ff};
                  if (barrier) begin
                     rsp_in.barrier_valid    = 1'b1;
                     rsp_in.barrier_resource = cur_ff.idx;
                     rsp_in.from_access      = eff_acc;
                     rsp_in.to_access        = cur_ff.acc;
                     if (crosses) begin
                        rsp_in.queue_crossing = 1'b1;
                        rsp_in.from_queue     = eff_queue;
                        rsp_in.to_queue       = cur_ff.pass_q;
                        rsp_in.release_step   = owner_step_wide[STEP_W-1:0];
                     end
                  end
               end
               OP_STEP: begin
                  if (saturated) begin
                     rsp_in.step_overflow = 1'b1;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
               OP_FINAL: begin
                  // ownership stays as it is
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {cur_ff.acc, eff_queue, eff_used, eff_step};
                  if (eff_acc != cur_ff.acc) begin
                     rsp_in.barrier_valid    = 1'b1;
                     rsp_in.barrier_resource = cur_ff.idx;
                     rsp_in.from_access      = eff_acc;
                     rsp_in.to_access        = cur_ff.acc;
                  end
               end
               OP_FRAME: begin
                  step_in      = '0;
                  own_valid_in = '0;
               end
               default: begin
               end
            endcase
            if (ram_wr_en) begin
               own_valid_in[cur_addr] = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign step_out_wide = 32'(step_in);

   // response with the step counter after this item's update
   always_comb begin
      rsp_out              = rsp_in;
      rsp_out.current_step = step_out_wide[STEP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         step_ff      <= '0;
         own_valid_ff <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         step_ff      <= step_in;
         own_valid_ff <= own_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (strobe_in) begin
         rsp_ff <= rsp_out;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff) == ST_EXEC)
      else $error("response without execute cycle");

   a_pop_starts_exec: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> state_ff == ST_EXEC)
      else $error("popped item not executed");

   a_cross_has_barrier: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.queue_crossing |-> rsp_ff.barrier_valid)
      else $error("queue crossing without barrier");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(step_ff) <= MAX_STEPS - 1)
      else $error("step counter past its limit");

endmodule
